/* design/bbis_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced bootstrap index sampler package
// Shared widths, register indexes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package bbis_pkg;

  localparam int MAX_ROWS_DEF = 256;

  localparam int FRAC_W     = 24;
  localparam int TOT_W      = 24;
  localparam int CNT_W      = 16;
  localparam int COL_W      = 16;
  localparam int ROWCFG_W   = 9;
  localparam int IDX_OUT_W  = 9;
  localparam int ROW_OUT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_ONE_OUT  = 2'd2;

  typedef struct packed {
    logic start;
    logic fill;
    logic mod_init;
    logic mod_step;
    logic held_rd;
    logic held_eval;
    logic mul;
    logic walk;
    logic finish;
  } bbis_cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_last;
    logic mod_last;
    logic walk_done;
    logic out_free;
  } bbis_status_t;

endpackage
`default_nettype wire

/* design/bbis_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced bootstrap index sampler controller
// Sequences one draw at a time: count load, column modulo, held-out read,
// scaling, cumulative walk and result write-back.
// ----------------------------------------------------------------------------
module bbis_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  bbis_pkg::bbis_status_t status_i,
  output bbis_pkg::bbis_cmd_t    cmd_o
);
  import bbis_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_MODI = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_HEV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_WALK = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.need_fill ? S_FILL : S_MODI;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) state_d = S_MODI;
      end
      S_MODI: begin
        cmd_o.mod_init = 1'b1;
        state_d        = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_HRD;
      end
      S_HRD: begin
        cmd_o.held_rd = 1'b1;
        state_d       = S_HEV;
      end
      S_HEV: begin
        cmd_o.held_eval = 1'b1;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/bbis_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced bootstrap index sampler datapath
// Holds the configuration, the per-index count memory, the matrix position,
// the serial column modulo unit, the draw scaler, the cumulative walk and the
// output register.
// ----------------------------------------------------------------------------
module bbis_datapath #(
  parameter int MAX_ROWS = bbis_pkg::MAX_ROWS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [bbis_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [bbis_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire  [bbis_pkg::FRAC_W-1:0]        frac_i,
  input  bbis_pkg::bbis_cmd_t                cmd_i,
  output bbis_pkg::bbis_status_t             status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [bbis_pkg::IDX_OUT_W-1:0]     sample_index_o,
  output logic [bbis_pkg::ROW_OUT_W-1:0]     row_position_o,
  output logic [bbis_pkg::COL_W-1:0]         column_position_o,
  output logic                               matrix_done_o
);
  import bbis_pkg::*;

  localparam int IW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int DW = CNT_W + NW;
  localparam int SW = $clog2(COL_W);
  localparam int PW = NW + CNT_W;

  logic [ROWCFG_W-1:0] row_count_q;
  logic [CNT_W-1:0]    resample_count_q;
  logic                loo_q;

  logic [NW-1:0]       n_eff;
  logic [CNT_W-1:0]    b_eff;

  logic [CNT_W-1:0]    cnt_mem [MAX_ROWS];
  logic                mem_we;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [CNT_W-1:0]    mem_wdata, mem_rdata_q;

  logic [TOT_W-1:0]    total_q;
  logic [IW-1:0]       row_q;
  logic [COL_W-1:0]    col_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [IW-1:0]       fcnt_q;
  logic [COL_W-1:0]    div_q;
  logic [NW-1:0]       rem_q;
  logic [SW-1:0]       mstep_q;
  logic [IW-1:0]       hold_q;
  logic                holding_q;
  logic [TOT_W-1:0]    scale_q;
  logic [FRAC_W-1:0]   k_q;
  logic [IW-1:0]       wa_q, pidx_q;
  logic                pv_q;
  logic [DW-1:0]       sum_q;
  logic [NW-1:0]       chosen_q;
  logic [CNT_W-1:0]    ccnt_q;

  logic [PW-1:0]       nb_prod;
  logic [NW:0]         mod_try;
  logic [NW-1:0]       rem_next;
  logic                holding_d;
  logic [CNT_W-1:0]    held;
  logic [TOT_W-1:0]    scale_d;
  logic [2*FRAC_W-1:0] draw_prod;
  logic                skip;
  logic [DW-1:0]       sum_next;
  logic                hit;
  logic                row_last, col_last, done;
  logic [TOT_W-1:0]    total_dec;

  always_comb begin
    if (row_count_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      n_eff = NW'(MAX_ROWS);
    end else begin
      n_eff = NW'(row_count_q);
    end
    b_eff = (resample_count_q == '0) ? CNT_W'(1) : resample_count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q      <= ROWCFG_W'(1);
      resample_count_q <= CNT_W'(1);
      loo_q            <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:      row_count_q      <= cfg_data_i[ROWCFG_W-1:0];
        CFG_RESAMPLE_COUNT: resample_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_LEAVE_ONE_OUT:  loo_q            <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign nb_prod  = PW'(n_eff) * PW'(b_eff);
  assign mod_try  = {rem_q, div_q[COL_W-1]};
  assign rem_next = (mod_try >= {1'b0, n_eff}) ? NW'(mod_try - {1'b0, n_eff})
                                               : NW'(mod_try);

  always_comb begin
    holding_d = loo_q && (TOT_W'(mem_rdata_q) != total_q);
    held      = holding_d ? mem_rdata_q : '0;
    scale_d   = (total_q >= TOT_W'(held)) ? total_q - TOT_W'(held) : '0;
  end

  assign draw_prod = frac_q * scale_q;

  always_comb begin
    skip     = holding_q && (pidx_q == hold_q);
    sum_next = sum_q + (skip ? '0 : DW'(mem_rdata_q));
    hit      = 32'(k_q) < 32'(sum_next);
  end

  always_comb begin
    row_last  = (NW'(row_q) + NW'(1)) >= n_eff;
    col_last  = ((17)'(col_q) + 17'd1) >= (17)'(b_eff);
    done      = row_last && col_last;
    total_dec = (total_q != '0) ? total_q - TOT_W'(1) : '0;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fcnt_q;
    mem_wdata = b_eff;
    if (cmd_i.fill) begin
      mem_we = 1'b1;
    end else if (cmd_i.finish && (chosen_q != '0) && (ccnt_q != '0)) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(chosen_q - NW'(1));
      mem_wdata = ccnt_q - CNT_W'(1);
    end
    mem_raddr = cmd_i.held_rd ? IW'(rem_q) : wa_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= cnt_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      fcnt_q  <= '0;
      mstep_q <= '0;
      wa_q    <= '0;
      pv_q    <= 1'b0;
    end else begin
      if (cmd_i.start) fcnt_q <= '0;
      if (cmd_i.fill) begin
        fcnt_q  <= fcnt_q + IW'(1);
        total_q <= TOT_W'(nb_prod);
        row_q   <= '0;
        col_q   <= '0;
      end
      if (cmd_i.mod_init) mstep_q <= '0;
      if (cmd_i.mod_step) mstep_q <= mstep_q + SW'(1);
      if (cmd_i.mul) begin
        wa_q <= '0;
        pv_q <= 1'b0;
      end
      if (cmd_i.walk) begin
        wa_q <= wa_q + IW'(1);
        pv_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        total_q <= done ? '0 : total_dec;
        if (row_last) begin
          row_q <= '0;
          col_q <= col_last ? '0 : col_q + COL_W'(1);
        end else begin
          row_q <= row_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) frac_q <= frac_i;
    if (cmd_i.mod_init) begin
      div_q <= col_q;
      rem_q <= '0;
    end
    if (cmd_i.mod_step) begin
      div_q <= {div_q[COL_W-2:0], 1'b0};
      rem_q <= rem_next;
    end
    if (cmd_i.held_rd) hold_q <= IW'(rem_q);
    if (cmd_i.held_eval) begin
      holding_q <= holding_d;
      scale_q   <= scale_d;
    end
    if (cmd_i.mul) begin
      k_q   <= draw_prod[2*FRAC_W-1:FRAC_W];
      sum_q <= '0;
    end
    if (cmd_i.walk) begin
      pidx_q <= wa_q;
      if (pv_q) sum_q <= sum_next;
      if (status_o.walk_done) begin
        chosen_q <= hit ? NW'(pidx_q) + NW'(1) : '0;
        ccnt_q   <= mem_rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_index_o    <= IDX_OUT_W'(chosen_q);
      row_position_o    <= ROW_OUT_W'(row_q);
      column_position_o <= col_q;
      matrix_done_o     <= done;
    end
  end

  always_comb begin
    status_o.need_fill = (total_q == '0);
    status_o.fill_last = NW'(fcnt_q) == (n_eff - NW'(1));
    status_o.mod_last  = (mstep_q == SW'(COL_W - 1));
    status_o.walk_done = pv_q && (hit || (NW'(pidx_q) == (n_eff - NW'(1))));
    status_o.out_free  = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

/* design/balanced_bootstrap_index_sampler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Balanced bootstrap index sampler
// Turns one random fraction per transfer into the next index of an n by B
// balanced bootstrap matrix, filled column by column, with optional bootknife
// hold-out of index (column mod n).
// ----------------------------------------------------------------------------
// One draw is handled at a time. A draw takes the fraction, runs the serial
// column modulo, reads the held-out count, does the scaling multiply, walks
// the cumulative counts through the single read port of the count memory and
// hands the result to the output register. The first draw of every matrix
// loads the counts before the rest. A finished result waits in the output
// register while the next fraction is taken; a draw stalls at its end only
// while the previous result is still waiting there.
module balanced_bootstrap_index_sampler #(
  parameter int MAX_ROWS = bbis_pkg::MAX_ROWS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [bbis_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [bbis_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: random_fraction[23:0].
  input  wire  [bbis_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // Fields from bit 0: sample_index[8:0], row_position[16:9],
  // column_position[32:17], zero fill[39:33].
  output logic [bbis_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import bbis_pkg::*;

  bbis_cmd_t              cmd;
  bbis_status_t           status;
  logic [IDX_OUT_W-1:0]   sample_index;
  logic [ROW_OUT_W-1:0]   row_position;
  logic [COL_W-1:0]       column_position;

  bbis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbis_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .frac_i            (s_axis_tdata[FRAC_W-1:0]),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .sample_index_o    (sample_index),
    .row_position_o    (row_position),
    .column_position_o (column_position),
    .matrix_done_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {
    (M_TDATA_W - IDX_OUT_W - ROW_OUT_W - COL_W)'(0),
    column_position,
    row_position,
    sample_index
  };

`ifndef SYNTHESIS
  a_one_draw_at_a_time : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("input taken while a draw is in progress");

  a_result_after_draw : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready)
  ) else $error("result appeared without a draw in progress");

  a_index_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[IDX_OUT_W-1:0]) <= MAX_ROWS)
  ) else $error("sample index beyond the row limit");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the balanced bootstrap index sampler
// Drives random fractions over the input stream and predicts every draw:
// the chosen index, its row and column in the matrix and the end-of-matrix
// flag. Short directed sequences cover the register extremes, bootknife
// hold-out and register changes in the middle of a matrix. Random phases
// follow, with bursty input, a stalling output and two long output stalls.
// ----------------------------------------------------------------------------
module tb;
  import bbis_pkg::*;

  localparam int unsigned DRAW_TARGET    = 650;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned FIRST_HOLD_AT  = 150;
  localparam int unsigned SECOND_HOLD_AT = 480;
  localparam int unsigned DRAIN_CYCLES   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 10000;

  typedef enum {RX_FREE, RX_BUSY, RX_CHOKED} rx_mode_e;

  class draw_scoreboard;
    typedef struct {
      bit [IDX_OUT_W-1:0] index;
      bit [ROW_OUT_W-1:0] row;
      bit [COL_W-1:0]     column;
      bit                 last;
    } draw_t;

    bit [CNT_W-1:0]    counts [MAX_ROWS_DEF];
    bit [TOT_W-1:0]    remaining;
    bit [ROW_OUT_W-1:0] row;
    bit [COL_W-1:0]    column;
    bit [ROWCFG_W-1:0] row_reg = 1;
    bit [CNT_W-1:0]    resample_reg = 1;
    bit                knife_reg;
    draw_t             draws_q[$];
    int unsigned       errors;

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ROW_COUNT: begin
          row_reg = value[ROWCFG_W-1:0];
        end
        CFG_RESAMPLE_COUNT: begin
          resample_reg = value;
        end
        CFG_LEAVE_ONE_OUT: begin
          knife_reg = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned pending();
      return draws_q.size();
    endfunction

    // Predicts one draw and returns its end-of-matrix flag.
    function bit note_draw(bit [FRAC_W-1:0] frac);
      int unsigned n, b, hold_idx, walk_sum, j;
      bit [TOT_W-1:0] scale, pick;
      bit [2*FRAC_W-1:0] product;
      bit [CNT_W-1:0] held;
      bit [IDX_OUT_W-1:0] chosen;
      bit holding, done;
      draw_t d;
      n = (row_reg == 0) ? 1 : (row_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : row_reg;
      b = (resample_reg == 0) ? 1 : resample_reg;
      if (remaining == 0) begin
        for (j = 0; j < n; j++) counts[j] = b[CNT_W-1:0];
        remaining = TOT_W'(n * b);
        row = 0;
        column = 0;
      end
      held = 0;
      holding = 0;
      hold_idx = 0;
      if (knife_reg) begin
        hold_idx = column % n;
        if (counts[hold_idx] != remaining) begin
          held = counts[hold_idx];
          holding = 1;
        end
      end
      scale = (remaining >= held) ? remaining - held : 0;
      product = frac * scale;
      pick = product[2*FRAC_W-1:FRAC_W];
      chosen = 0;
      walk_sum = 0;
      for (j = 0; j < n; j++) begin
        if (!(holding && j == hold_idx)) walk_sum += counts[j];
        if (pick < walk_sum) begin
          chosen = IDX_OUT_W'(j + 1);
          break;
        end
      end
      if (chosen != 0 && counts[chosen-1] != 0) counts[chosen-1]--;
      if (remaining != 0) remaining--;
      done = (row + 1 >= n) && (column + 1 >= b);
      d.index = chosen;
      d.row = row;
      d.column = column;
      d.last = done;
      draws_q.push_back(d);
      if (row + 1 >= n) begin
        row = 0;
        if (column + 1 >= b) column = 0;
        else column++;
      end else begin
        row++;
      end
      if (done) remaining = 0;
      return done;
    endfunction

    task report(string what);
      if (errors < 100) $display("tb: mismatch: %s", what);
      errors++;
    endtask

    task check_draw(logic [M_TDATA_W-1:0] data, logic last);
      draw_t want;
      if (draws_q.size() == 0) begin
        report($sformatf("draw with nothing expected, tdata %h", data));
        return;
      end
      want = draws_q.pop_front();
      if (data[8:0] !== want.index)
        report($sformatf("sample index %0d, expected %0d", data[8:0], want.index));
      if (data[16:9] !== want.row)
        report($sformatf("row %0d, expected %0d", data[16:9], want.row));
      if (data[32:17] !== want.column)
        report($sformatf("column %0d, expected %0d", data[32:17], want.column));
      if (last !== want.last)
        report($sformatf("matrix end %b, expected %b", last, want.last));
      if (data[39:33] !== '0)
        report($sformatf("fill bits %h not zero", data[39:33]));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire  [M_TDATA_W-1:0]  m_axis_tdata;
  wire                   m_axis_tlast;

  draw_scoreboard sb = new();
  bit [FRAC_W-1:0] frac_script[$];
  int unsigned draws_accepted;
  int unsigned burst_left;
  int unsigned gap;
  bit steady;
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned mode_left;
  rx_mode_e rx_mode = RX_FREE;
  int unsigned quiet_cycles;

  balanced_bootstrap_index_sampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic put_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(int unsigned rows, int unsigned resamples, int unsigned knife);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    put_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
    put_reg(CFG_RESAMPLE_COUNT, CFG_DATA_W'(resamples));
    put_reg(CFG_LEAVE_ONE_OUT, CFG_DATA_W'(knife));
    cfg_we_i <= 1'b0;
  endtask

  // Sends up to limit fractions; with to_done set, it stops after the end of a matrix.
  task automatic send_draws(int unsigned limit, bit to_done);
    int unsigned sent;
    bit [FRAC_W-1:0] frac;
    bit done;
    sent = 0;
    done = 0;
    while (sent < limit && !(to_done && done)) begin
      if (frac_script.size() != 0) begin
        frac = frac_script.pop_front();
      end else begin
        case ($urandom_range(0, 7))
          0: frac = '0;
          1: frac = '1;
          default: frac = FRAC_W'($urandom);
        endcase
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= frac;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      done = sb.note_draw(frac);
      draws_accepted++;
      sent++;
      if (burst_left != 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = steady ? 0 : $urandom_range(1, 30);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_draw(m_axis_tdata, m_axis_tlast);
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_done < 2 &&
                 draws_accepted >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 300);
        case ($urandom_range(0, 2))
          0: rx_mode = RX_FREE;
          1: rx_mode = RX_BUSY;
          default: rx_mode = RX_CHOKED;
        endcase
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE: m_axis_tready <= 1'b1;
        RX_BUSY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_raw, b_val, left, burst_len;
    bit [CFG_DATA_W-1:0] row_data, knife_data;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One by one matrices at both ends of the fraction range.
    configure(1, 1, 0);
    frac_script = '{24'h000000, 24'hFFFFFF};
    send_draws(2, 0);

    // Shrinking the column count past the current column ends the matrix early.
    configure(2, 4, 0);
    send_draws(6, 0);
    configure(2, 2, 1);
    send_draws(10, 1);

    // A full bootknife matrix.
    configure(3, 2, 1);
    frac_script = '{24'h000000, 24'hFFFFFF, 24'h800000};
    send_draws(10, 1);

    // Fewer rows in mid-matrix: high fractions find no index.
    configure(4, 3, 0);
    frac_script = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
    send_draws(5, 0);
    configure(2, 3, 0);
    frac_script = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
    send_draws(10, 1);

    // Out-of-range register values are clamped.
    configure(0, 0, 0);
    send_draws(1, 0);

    // Largest matrix. This also loads every count entry, so later row count
    // changes never read entries that were never loaded.
    configure(300, 16'hFFFF, 1);
    frac_script = '{24'h000000, 24'hFFFFFF};
    send_draws(2, 0);

    while (draws_accepted < DRAW_TARGET) begin
      case ($urandom_range(0, 9))
        0: n_raw = 256;
        1: n_raw = $urandom_range(65, 255);
        2, 3: n_raw = $urandom_range(9, 64);
        4: n_raw = $urandom_range(0, 511);
        default: n_raw = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: b_val = 65535;
        1: b_val = $urandom_range(0, 65535);
        2, 3: b_val = $urandom_range(5, 40);
        default: b_val = $urandom_range(1, 4);
      endcase
      row_data = CFG_DATA_W'(n_raw);
      knife_data = CFG_DATA_W'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        row_data[15:9] = 7'($urandom);
        knife_data[15:1] = 15'($urandom);
      end
      configure(row_data, b_val, knife_data);
      steady = ($urandom_range(0, 3) == 0);
      left = DRAW_TARGET - draws_accepted;
      if ($urandom_range(0, 3) != 0) begin
        send_draws((left < 260) ? left : 260, 1);
      end else begin
        burst_len = $urandom_range(5, 40);
        send_draws((left < burst_len) ? left : burst_len, 0);
      end
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
